// ===== hw/rtl/imm_pkg.sv =====
package imm_pkg;

  localparam int SIZE_W    = 3;
  localparam int IDX_W     = 2;
  localparam int SUM_W     = 35;
  localparam int CFG_IDX_W = 2;
  localparam int IDX_LIMIT = 4;

  localparam logic [CFG_IDX_W-1:0] REG_LEFT_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_COLS = 2'd2;

  localparam logic [SIZE_W-1:0] LEFT_ROWS_RST  = 3'd2;
  localparam logic [SIZE_W-1:0] INNER_SIZE_RST = 3'd3;
  localparam logic [SIZE_W-1:0] RIGHT_COLS_RST = 3'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_WAIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic             left_we;
    logic             right_we;
    logic             issue;
    logic             first;
    logic             last_k;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] k;
    logic             load_out;
    logic             out_last;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic sum_ready;
    logic out_free;
  } dp_status_t;

  // input item header seen by the controller
  typedef struct packed {
    logic             valid;
    logic             which;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             start;
  } in_req_t;

  // zero acts as one, anything above the limit saturates
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                 input logic [SIZE_W-1:0] lim);
    logic [SIZE_W-1:0] r;
    r = v;
    if (r == '0) r = 3'd1;
    if (r > lim) r = lim;
    return r;
  endfunction

endpackage

// ===== hw/rtl/imm_in_if.sv =====
interface imm_in_if #(
  parameter int ELEMENT_BITS = 16
);
  logic                           valid;
  logic                           ready;
  logic                           which_matrix;
  logic [1:0]                     row_index;
  logic [1:0]                     col_index;
  logic signed [ELEMENT_BITS-1:0] element;
  logic                           start_product;

  modport source (output valid, which_matrix, row_index, col_index, element, start_product,
                  input ready);
  modport sink   (input valid, which_matrix, row_index, col_index, element, start_product,
                  output ready);
endinterface

// ===== hw/rtl/imm_out_if.sv =====
interface imm_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         out_row;
  logic [1:0]         out_col;
  logic signed [34:0] product_sum;
  logic               last_entry;

  modport source (output valid, out_row, out_col, product_sum, last_entry, input ready);
  modport sink   (input valid, out_row, out_col, product_sum, last_entry, output ready);
endinterface

// ===== hw/rtl/imm_cfg_if.sv =====
interface imm_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] reg_index;
  logic [2:0] wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

// ===== hw/rtl/imm_ram.sv =====
module imm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/imm_ctrl.sv =====
module imm_ctrl #(
  parameter int MAX_ROWS  = 4,
  parameter int MAX_INNER = 4,
  parameter int MAX_COLS  = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  imm_pkg::in_req_t         req,
  output logic                     in_ready,
  input  logic                     cfg_valid,
  input  logic [1:0]               cfg_index,
  input  logic [2:0]               cfg_data,
  output logic                     cfg_ready,
  input  imm_pkg::dp_status_t      status,
  output imm_pkg::ctl_cmd_t        cmd
);
  import imm_pkg::*;

  localparam logic [SIZE_W-1:0] ROW_LIM   = SIZE_W'((MAX_ROWS  < IDX_LIMIT) ? MAX_ROWS  : IDX_LIMIT);
  localparam logic [SIZE_W-1:0] INNER_LIM = SIZE_W'((MAX_INNER < IDX_LIMIT) ? MAX_INNER : IDX_LIMIT);
  localparam logic [SIZE_W-1:0] COL_LIM   = SIZE_W'((MAX_COLS  < IDX_LIMIT) ? MAX_COLS  : IDX_LIMIT);

  state_t            state_r, state_nxt;
  logic [SIZE_W-1:0] left_rows_r, inner_size_r, right_cols_r;
  logic [IDX_W-1:0]  i_r, j_r, k_r;
  logic [IDX_W-1:0]  i_nxt, j_nxt, k_nxt;
  logic [SIZE_W-1:0] nr, nk, nc;
  logic              accept;
  logic              last_i, last_j, last_k;

  assign nr = eff_size(left_rows_r, ROW_LIM);
  assign nk = eff_size(inner_size_r, INNER_LIM);
  assign nc = eff_size(right_cols_r, COL_LIM);

  assign cfg_ready = 1'b1;
  assign accept    = req.valid && (state_r == S_IDLE);
  assign last_i    = ({1'b0, i_r} == (nr - 3'd1));
  assign last_j    = ({1'b0, j_r} == (nc - 3'd1));
  assign last_k    = ({1'b0, k_r} == (nk - 3'd1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      left_rows_r  <= LEFT_ROWS_RST;
      inner_size_r <= INNER_SIZE_RST;
      right_cols_r <= RIGHT_COLS_RST;
      i_r          <= '0;
      j_r          <= '0;
      k_r          <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_LEFT_ROWS:  left_rows_r  <= cfg_data;
          REG_INNER_SIZE: inner_size_r <= cfg_data;
          REG_RIGHT_COLS: right_cols_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept && req.start) state_nxt = S_RUN;
      S_RUN:  if (last_k) state_nxt = S_WAIT;
      S_WAIT: begin
        if (status.sum_ready && status.out_free) begin
          state_nxt = (last_i && last_j) ? S_IDLE : S_RUN;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and counters
  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.i        = i_r;
    cmd.j        = j_r;
    cmd.k        = k_r;
    cmd.last_k   = last_k;
    cmd.out_last = last_i && last_j;
    i_nxt        = i_r;
    j_nxt        = j_r;
    k_nxt        = k_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.left_we  = accept && !req.which &&
                       ({1'b0, req.row} < nr) && ({1'b0, req.col} < nk);
        cmd.right_we = accept && req.which &&
                       ({1'b0, req.row} < nk) && ({1'b0, req.col} < nc);
        if (accept && req.start) begin
          i_nxt = '0;
          j_nxt = '0;
          k_nxt = '0;
        end
      end
      S_RUN: begin
        cmd.issue = 1'b1;
        cmd.first = (k_r == '0);
        k_nxt     = last_k ? '0 : k_r + 2'd1;
      end
      S_WAIT: begin
        if (status.sum_ready && status.out_free) begin
          cmd.load_out = 1'b1;
          if (last_j) begin
            j_nxt = '0;
            i_nxt = i_r + 2'd1;
          end else begin
            j_nxt = j_r + 2'd1;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/imm_datapath.sv =====
module imm_datapath #(
  parameter int MAX_ROWS     = 4,
  parameter int MAX_INNER    = 4,
  parameter int MAX_COLS     = 4,
  parameter int ELEMENT_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  imm_pkg::ctl_cmd_t         cmd,
  output imm_pkg::dp_status_t       status,
  input  logic [1:0]                in_row,
  input  logic [1:0]                in_col,
  input  logic [ELEMENT_BITS-1:0]   in_element,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_row,
  output logic [1:0]                out_col,
  output logic signed [34:0]        out_sum,
  output logic                      out_last
);
  import imm_pkg::*;

  localparam int LDEPTH = MAX_ROWS * MAX_INNER;
  localparam int RDEPTH = MAX_INNER * MAX_COLS;
  localparam int LAW    = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
  localparam int RAW    = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;
  localparam int PW     = 2 * ELEMENT_BITS;

  logic [LAW-1:0]          l_waddr, l_raddr;
  logic [RAW-1:0]          r_waddr, r_raddr;
  logic [ELEMENT_BITS-1:0] l_rdata, r_rdata;

  logic                 rd_v_r, rd_first_r, rd_last_r;
  logic                 mul_v_r, mul_first_r, mul_last_r;
  logic signed [PW-1:0] prod_r;
  logic signed [63:0]   prod_ext;
  logic [SUM_W-1:0]     acc_r;
  logic                 done_r;
  logic                 out_valid_r, out_last_r;
  logic [IDX_W-1:0]     out_row_r, out_col_r;
  logic [SUM_W-1:0]     out_sum_r;

  assign l_waddr = LAW'(in_row * MAX_INNER + in_col);
  assign r_waddr = RAW'(in_row * MAX_COLS + in_col);
  assign l_raddr = LAW'(cmd.i * MAX_INNER + cmd.k);
  assign r_raddr = RAW'(cmd.k * MAX_COLS + cmd.j);

  imm_ram #(.WIDTH(ELEMENT_BITS), .DEPTH(LDEPTH), .AW(LAW)) u_left (
    .clk   (clk),
    .we    (cmd.left_we),
    .waddr (l_waddr),
    .wdata (in_element),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  imm_ram #(.WIDTH(ELEMENT_BITS), .DEPTH(RDEPTH), .AW(RAW)) u_right (
    .clk   (clk),
    .we    (cmd.right_we),
    .waddr (r_waddr),
    .wdata (in_element),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  // product wraps mod 2^64 before the 35-bit mask
  assign prod_ext = 64'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r      <= 1'b0;
      mul_v_r     <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_v_r  <= cmd.issue;
      mul_v_r <= rd_v_r;
      if (mul_v_r && mul_last_r) begin
        done_r <= 1'b1;
      end else if (cmd.load_out) begin
        done_r <= 1'b0;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_first_r  <= cmd.first;
    rd_last_r   <= cmd.last_k;
    mul_first_r <= rd_first_r;
    mul_last_r  <= rd_last_r;
    prod_r      <= $signed(l_rdata) * $signed(r_rdata);
    if (mul_v_r) begin
      acc_r <= mul_first_r ? prod_ext[SUM_W-1:0] : acc_r + prod_ext[SUM_W-1:0];
    end
    if (cmd.load_out) begin
      out_row_r  <= cmd.i;
      out_col_r  <= cmd.j;
      out_sum_r  <= acc_r;
      out_last_r <= cmd.out_last;
    end
  end

  assign status.sum_ready = done_r;
  assign status.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_sum   = $signed(out_sum_r);
  assign out_last  = out_last_r;

endmodule

// ===== hw/rtl/integer_matrix_multiply.sv =====
// Signed integer matrix multiplier, left (rows x inner) times right (inner x cols).
// in_ch  : one beat loads one element into the left or right store at row/col.
//          Elements outside the configured sizes are dropped. A beat with
//          start_product set stores its element, then runs the product.
// out_ch : one beat per result entry, row-major, last_entry on the final one.
// cfg_ch : writes left_rows / inner_size / right_cols; always ready. Write only
//          while idle.
// Load beats: one per cycle while idle. During a product in_ready is low.
// Product: each entry issues inner_size reads, which pass through the RAM read
//   register, the multiplier register and the accumulator; the single
//   multiply-accumulate unit works out one entry after another.
// The output register holds a finished entry while the receiver stalls; the
//   next entry's sums run meanwhile and wait for the register to free up.
//   After the final entry the block takes loads again while it is still pending.
// Reset: sizes return to 2 x 3 x 2, no beat is pending. Stores are not cleared;
//   every used element must be loaded before the start beat.
module integer_matrix_multiply #(
  parameter int MAX_ROWS     = 4,
  parameter int MAX_INNER    = 4,
  parameter int MAX_COLS     = 4,
  parameter int ELEMENT_BITS = 16
) (
  input logic        clk,
  input logic        rst_n,
  imm_in_if.sink     in_ch,
  imm_out_if.source  out_ch,
  imm_cfg_if.sink    cfg_ch
);
  import imm_pkg::*;

  in_req_t    req;
  ctl_cmd_t   cmd;
  dp_status_t status;

  assign req.valid = in_ch.valid;
  assign req.which = in_ch.which_matrix;
  assign req.row   = in_ch.row_index;
  assign req.col   = in_ch.col_index;
  assign req.start = in_ch.start_product;

  // sequencer: sizes, loop counters, store write enables
  imm_ctrl #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_INNER (MAX_INNER),
    .MAX_COLS  (MAX_COLS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .in_ready  (in_ch.ready),
    .cfg_valid (cfg_ch.valid),
    .cfg_index (cfg_ch.reg_index),
    .cfg_data  (cfg_ch.wr_data),
    .cfg_ready (cfg_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // stores, multiply-accumulate pipe, output register
  imm_datapath #(
    .MAX_ROWS     (MAX_ROWS),
    .MAX_INNER    (MAX_INNER),
    .MAX_COLS     (MAX_COLS),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_row     (in_ch.row_index),
    .in_col     (in_ch.col_index),
    .in_element (in_ch.element),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_row    (out_ch.out_row),
    .out_col    (out_ch.out_col),
    .out_sum    (out_ch.product_sum),
    .out_last   (out_ch.last_entry)
  );

endmodule

// ===== hw/rtl/imm_checker.sv =====
module imm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_start,
  input logic        out_valid,
  input logic        out_ready,
  input logic [34:0] out_sum,
  input logic        out_last
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sum) && $stable(out_last))
    else $error("stalled result beat changed");

  // a start beat closes the input side
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_start |=> !in_ready)
    else $error("input ready after start beat");

  // mid-product entries pending means no loads are taken
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input ready while product incomplete");

  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result beat right after reset");

endmodule

bind integer_matrix_multiply imm_checker u_imm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_start  (in_ch.start_product),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_sum   (out_ch.product_sum),
  .out_last  (out_ch.last_entry)
);
